// ----- hw/rtl/ism_pkg.sv -----
package ism_pkg;

    typedef enum logic
    {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef struct packed
    {
        logic         valid;
        func_t        func;
        logic [31:0]  a;
        logic [31:0]  b;
        logic         hit;
    } slot_t;

    localparam int VALUE_W = 32;

endpackage

// ----- hw/rtl/ism_cell.sv -----
module ism_cell #(
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  ism_pkg::slot_t  slot_in,
    input  logic [CW-1:0]   tag_in,
    output ism_pkg::slot_t  slot_out,
    output logic [CW-1:0]   tag_out
);
    import ism_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic signed [VALUE_W-1:0] lo_reg;
    logic signed [VALUE_W-1:0] hi_reg;
    logic                      valid_reg;
    func_t                     func_reg;
    logic [VALUE_W-1:0]        a_reg;
    logic [VALUE_W-1:0]        b_reg;
    logic                      hit_reg;
    logic [CW-1:0]             tag_reg;

    logic write_here;
    logic match;
    logic signed [VALUE_W-1:0] pt;

    assign pt         = signed'(slot_in.a);
    assign write_here = slot_in.valid && (slot_in.func == FUNC_LOAD) && (tag_in == MY_IDX);
    assign match      = slot_in.valid && (slot_in.func == FUNC_QUERY) && (tag_in > MY_IDX)
                        && (lo_reg <= pt) && (pt <= hi_reg);

    // stored interval of this cell
    always_ff @(posedge clk)
    begin
        if (advance && write_here)
        begin
            lo_reg <= signed'(slot_in.a);
            hi_reg <= signed'(slot_in.b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= slot_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            func_reg <= slot_in.func;
            a_reg    <= slot_in.a;
            b_reg    <= slot_in.b;
            hit_reg  <= slot_in.hit | match;
            tag_reg  <= tag_in;
        end
    end

    always_comb
    begin
        slot_out.valid = valid_reg;
        slot_out.func  = func_reg;
        slot_out.a     = a_reg;
        slot_out.b     = b_reg;
        slot_out.hit   = hit_reg;
        tag_out        = tag_reg;
    end

endmodule

// ----- hw/rtl/interval_set_membership.sv -----
// channel   | direction | tdata (low bit up)                  | tuser
// ----------+-----------+-------------------------------------+-------------------------
// s_axis    | in        | left_end[31:0] right_end[31:0] point | func (0 load, 1 query)
// m_axis    | out       | found, padded to 8 bits             | none
//
// one transfer per cycle on the input unless m_axis stalls; a query passes every cell, then the output register
// the row holds one cell per storable interval, MAX_INTERVALS cells in all
// reset clears the fill count and all cell valid bits; stored bounds are not cleared
// a stall on m_axis freezes the whole row and drops s_tready in the same cycle
module interval_set_membership #(
    parameter int MAX_INTERVALS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // left_end, right_end, point
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // found, zero pad
);
    import ism_pkg::*;

    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_INTERVALS);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          found_reg;
    logic          advance;
    logic          accept;
    func_t         in_func;

    slot_t         slot [MAX_INTERVALS+1];
    logic [CW-1:0] tag  [MAX_INTERVALS+1];

    assign advance  = !(out_valid_reg && !m_tready);
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;
    assign in_func  = func_t'(s_tuser[0]);

    always_comb
    begin
        slot[0].valid = 1'b0;
        slot[0].func  = in_func;
        slot[0].a     = s_tdata[31:0];
        slot[0].b     = s_tdata[63:32];
        slot[0].hit   = 1'b0;
        tag[0]        = count_reg;
        count_next    = count_reg;
        case (in_func)
            FUNC_LOAD:
            begin
                slot[0].valid = accept && (count_reg != FULL);
                if (accept && (count_reg != FULL))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                slot[0].valid = accept;
                slot[0].a     = s_tdata[95:64];
            end
            default:
            begin
                slot[0].valid = 1'b0;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_INTERVALS; gi++)
        begin : g_cell
            ism_cell #(
                .CW  (CW),
                .IDX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .slot_in  (slot[gi]),
                .tag_in   (tag[gi]),
                .slot_out (slot[gi+1]),
                .tag_out  (tag[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = slot[MAX_INTERVALS].valid
                             && (slot[MAX_INTERVALS].func == FUNC_QUERY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            found_reg <= slot[MAX_INTERVALS].hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, found_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("fill count beyond capacity");

    a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_func == FUNC_LOAD) && (count_reg != FULL))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted load did not advance fill count");

    a_query_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_func == FUNC_QUERY)) |=> $stable(count_reg))
        else $error("query changed fill count");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(found_reg)))
        else $error("result changed while stalled");

endmodule
